>>> hw/rtl/lsra_pkg.sv
// ----------------------------------------------------------------------------
// lsra_pkg
// Request, outcome codes and fixed field widths of the register allocator.
// ----------------------------------------------------------------------------
package lsra_pkg;

	localparam int REQ_W  = 2;
	localparam int OUT_W  = 2;
	localparam int REG_W  = 5;
	localparam int MASK_W = 16;

	typedef logic [REQ_W-1:0]  req_t;
	typedef logic [OUT_W-1:0]  outc_t;
	typedef logic [REG_W-1:0]  reg_t;
	typedef logic [MASK_W-1:0] mask_t;

	localparam req_t REQ_CLEAR = 2'd0;
	localparam req_t REQ_FIXED = 2'd1;
	localparam req_t REQ_ALLOC = 2'd2;

	localparam outc_t OUTC_ASSIGNED = 2'd0;
	localparam outc_t OUTC_SPILLED  = 2'd1;
	localparam outc_t OUTC_ERROR    = 2'd2;

	localparam mask_t MASK_RESET = 16'hFFFF;

endpackage

>>> hw/rtl/linear_scan_register_allocator_core.sv
// ----------------------------------------------------------------------------
// linear_scan_register_allocator_core
// Linear-scan register allocator with fixed intervals and spill by furthest end.
// ----------------------------------------------------------------------------
// One request is worked at a time. A clear gives no result. A fixed load or a
// rejected request has its result staged and then moved into the output
// register once it is free. An allocation sweeps the active RAM and the fixed
// RAM side by side, one entry of each per cycle, and then passes the drain,
// decide and emit states before its first result reaches the output register;
// the sweep length is set by the one read port of each RAM. During the sweep
// the active entries that end at or before the new start are expired, the fixed
// intervals that overlap the new one mark their register as blocked, and the
// surviving active entry with the greatest end (lowest register on a tie) is
// kept as the eviction candidate. An eviction gives two results, the evicted
// interval first. A new request is taken while the last result still waits.
// Only registers 1..16 can ever be enabled, as the mask has 16 bits.
module linear_scan_register_allocator_core #(
	parameter int NUM_REGS   = 16,
	parameter int MAX_FIXED  = 16,
	parameter int POINT_BITS = 16,
	parameter int ID_BITS    = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_wr_en,
	input  lsra_pkg::mask_t      cfg_wr_data,
	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lsra_pkg::req_t       req_type,
	input  logic [ID_BITS-1:0]   interval_id,
	input  logic [POINT_BITS-1:0] start_point,
	input  logic [POINT_BITS-1:0] end_point,
	input  lsra_pkg::reg_t       fixed_register,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ID_BITS-1:0]   result_id,
	output lsra_pkg::outc_t      outcome,
	output lsra_pkg::reg_t       assigned_register,
	output logic                 last
);

	import lsra_pkg::*;

	localparam int AAW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int FAW = (MAX_FIXED > 1) ? $clog2(MAX_FIXED) : 1;
	localparam int CW  = $clog2(MAX_FIXED + 1);
	localparam int LEN = (NUM_REGS > MAX_FIXED) ? NUM_REGS : MAX_FIXED;
	localparam int KW  = $clog2(LEN + 1);
	localparam int RW  = $clog2(NUM_REGS + 1);
	localparam int AW_DATA = ID_BITS + POINT_BITS;
	localparam int FW_DATA = REG_W + 2 * POINT_BITS;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SWEEP  = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_EMIT_A = 3'd4;
	localparam logic [2:0] ST_EMIT_B = 3'd5;

	logic [2:0]            state_q;
	mask_t                 avail_q;
	logic [NUM_REGS-1:0]   act_vld_q;
	logic [NUM_REGS-1:0]   blocked_q;
	logic [CW-1:0]         fcount_q;
	logic [POINT_BITS-1:0] prev_start_q;

	// latched request
	logic [ID_BITS-1:0]    id_q;
	logic [POINT_BITS-1:0] s_q;
	logic [POINT_BITS-1:0] e_q;

	// sweep
	logic [KW-1:0]         cnt_q;
	logic                  sw_s1;
	logic                  f_ok_s1;
	logic                  a_ok_s1;
	logic [AAW-1:0]        idx_s1;
	logic                  best_vld_q;
	logic [AAW-1:0]        best_q;
	logic [POINT_BITS-1:0] best_end_q;
	logic [ID_BITS-1:0]    best_id_q;

	// pending results
	logic [ID_BITS-1:0]    ra_id_q;
	outc_t                 ra_oc_q;
	reg_t                  ra_reg_q;
	logic                  ra_last_q;
	logic [ID_BITS-1:0]    rb_id_q;
	reg_t                  rb_reg_q;

	// output register
	logic                  out_vld_q;
	logic [ID_BITS-1:0]    o_id_q;
	outc_t                 o_oc_q;
	reg_t                  o_reg_q;
	logic                  o_last_q;

	// RAM ports
	logic                  a_wr_en;
	logic [AAW-1:0]        a_wr_addr;
	logic [AW_DATA-1:0]    a_wr_data;
	logic                  a_rd_en;
	logic [AW_DATA-1:0]    a_rd_data;
	logic                  f_wr_en;
	logic [FW_DATA-1:0]    f_wr_data;
	logic                  f_rd_en;
	logic [FW_DATA-1:0]    f_rd_data;

	logic                  in_xfer;
	logic                  slot_free;
	logic                  emit_now;
	logic                  f_ok;
	logic                  a_ok;
	logic                  fix_bad;
	logic                  alloc_bad;

	logic [ID_BITS-1:0]    a_id;
	logic [POINT_BITS-1:0] a_end;
	reg_t                  f_reg;
	logic [POINT_BITS-1:0] f_start;
	logic [POINT_BITS-1:0] f_end;
	logic                  f_hit;

	logic [NUM_REGS-1:0]   free_mask;
	logic                  free_any;
	logic [AAW-1:0]        free_sel;
	logic                  evict;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign slot_free = !out_vld_q || !out_stall;
	assign emit_now  = slot_free && ((state_q == ST_EMIT_A) || (state_q == ST_EMIT_B));

	assign out_valid         = out_vld_q;
	assign result_id         = o_id_q;
	assign outcome           = o_oc_q;
	assign assigned_register = o_reg_q;
	assign last              = o_last_q;

	assign fix_bad = (fcount_q == CW'(MAX_FIXED)) || (start_point >= end_point) ||
		(fixed_register == '0) || (32'(fixed_register) > NUM_REGS);
	assign alloc_bad = (start_point < prev_start_q) || (start_point >= end_point);

	// sweep read issue
	assign f_ok    = (cnt_q < KW'(fcount_q));
	assign a_ok    = (32'(cnt_q) < NUM_REGS);
	assign f_rd_en = (state_q == ST_SWEEP) && f_ok;
	assign a_rd_en = (state_q == ST_SWEEP) && a_ok;

	assign {a_id, a_end}            = a_rd_data;
	assign {f_reg, f_start, f_end}  = f_rd_data;
	assign f_hit = sw_s1 && f_ok_s1 && (f_end > s_q) && (f_start < e_q);

	// free register pick, lowest first
	always_comb begin
		free_mask = '0;
		free_sel  = '0;
		for (int r = 0; r < NUM_REGS; r++) begin
			if (r < MASK_W) begin
				free_mask[r] = avail_q[r] && !act_vld_q[r] && !blocked_q[r];
			end
		end
		for (int r = NUM_REGS - 1; r >= 0; r--) begin
			if (free_mask[r]) begin
				free_sel = AAW'(r);
			end
		end
	end
	assign free_any = |free_mask;
	assign evict    = best_vld_q && (best_end_q > e_q);

	// at most one write per allocation, at decide time
	assign a_wr_en   = (state_q == ST_DECIDE) && (free_any || evict);
	assign a_wr_addr = free_any ? free_sel : best_q;
	assign a_wr_data = {id_q, e_q};

	assign f_wr_en   = in_xfer && (req_type == REQ_FIXED) && !fix_bad;
	assign f_wr_data = {fixed_register, start_point, end_point};

	lsra_ram #(
		.WIDTH(AW_DATA),
		.DEPTH(NUM_REGS)
	) u_act_ram (
		.clk    (clk),
		.wr_en  (a_wr_en),
		.wr_addr(a_wr_addr),
		.wr_data(a_wr_data),
		.rd_en  (a_rd_en),
		.rd_addr(cnt_q[AAW-1:0]),
		.rd_data(a_rd_data)
	);

	lsra_ram #(
		.WIDTH(FW_DATA),
		.DEPTH(MAX_FIXED)
	) u_fix_ram (
		.clk    (clk),
		.wr_en  (f_wr_en),
		.wr_addr(fcount_q[FAW-1:0]),
		.wr_data(f_wr_data),
		.rd_en  (f_rd_en),
		.rd_addr(cnt_q[FAW-1:0]),
		.rd_data(f_rd_data)
	);

	// payload of the sweep pipe and latched request
	always_ff @(posedge clk) begin
		f_ok_s1 <= f_ok;
		a_ok_s1 <= a_ok;
		idx_s1  <= cnt_q[AAW-1:0];
		if (in_xfer) begin
			id_q <= interval_id;
			s_q  <= start_point;
			e_q  <= end_point;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			avail_q      <= MASK_RESET;
			act_vld_q    <= '0;
			blocked_q    <= '0;
			fcount_q     <= '0;
			prev_start_q <= '0;
			cnt_q        <= '0;
			sw_s1        <= 1'b0;
			best_vld_q   <= 1'b0;
			best_q       <= '0;
			best_end_q   <= '0;
			best_id_q    <= '0;
			ra_id_q      <= '0;
			ra_oc_q      <= OUTC_ERROR;
			ra_reg_q     <= '0;
			ra_last_q    <= 1'b0;
			rb_id_q      <= '0;
			rb_reg_q     <= '0;
			out_vld_q    <= 1'b0;
			o_id_q       <= '0;
			o_oc_q       <= OUTC_ERROR;
			o_reg_q      <= '0;
			o_last_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				avail_q <= cfg_wr_data;
			end
			if (emit_now) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			sw_s1 <= (state_q == ST_SWEEP);

			// sweep data, in the cycle after the read
			if (sw_s1 && a_ok_s1 && act_vld_q[idx_s1]) begin
				if (a_end <= s_q) begin
					act_vld_q[idx_s1] <= 1'b0;
				end else if (!best_vld_q || (a_end > best_end_q)) begin
					best_vld_q <= 1'b1;
					best_q     <= idx_s1;
					best_end_q <= a_end;
					best_id_q  <= a_id;
				end
			end
			if (f_hit) begin
				for (int r = 0; r < NUM_REGS; r++) begin
					if (RW'(f_reg) == RW'(r + 1)) begin
						blocked_q[r] <= 1'b1;
					end
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						ra_id_q   <= interval_id;
						ra_last_q <= 1'b1;
						case (req_type)
							REQ_CLEAR: begin
								act_vld_q    <= '0;
								fcount_q     <= '0;
								prev_start_q <= '0;
							end
							REQ_FIXED: begin
								state_q  <= ST_EMIT_A;
								ra_oc_q  <= fix_bad ? OUTC_ERROR : OUTC_ASSIGNED;
								ra_reg_q <= fix_bad ? reg_t'(0) : fixed_register;
								if (!fix_bad) begin
									fcount_q <= fcount_q + 1'b1;
								end
							end
							REQ_ALLOC: begin
								if (alloc_bad) begin
									state_q  <= ST_EMIT_A;
									ra_oc_q  <= OUTC_ERROR;
									ra_reg_q <= '0;
								end else begin
									state_q      <= ST_SWEEP;
									prev_start_q <= start_point;
									cnt_q        <= '0;
									blocked_q    <= '0;
									best_vld_q   <= 1'b0;
								end
							end
							default: begin
								state_q  <= ST_EMIT_A;
								ra_oc_q  <= OUTC_ERROR;
								ra_reg_q <= '0;
							end
						endcase
					end
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (32'(cnt_q) == LEN - 1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= ST_EMIT_A;
					if (free_any) begin
						act_vld_q[free_sel] <= 1'b1;
						ra_id_q   <= id_q;
						ra_oc_q   <= OUTC_ASSIGNED;
						ra_reg_q  <= REG_W'(32'(free_sel) + 1);
						ra_last_q <= 1'b1;
					end else if (evict) begin
						ra_id_q   <= best_id_q;
						ra_oc_q   <= OUTC_SPILLED;
						ra_reg_q  <= '0;
						ra_last_q <= 1'b0;
						rb_id_q   <= id_q;
						rb_reg_q  <= REG_W'(32'(best_q) + 1);
					end else begin
						ra_id_q   <= id_q;
						ra_oc_q   <= OUTC_SPILLED;
						ra_reg_q  <= '0;
						ra_last_q <= 1'b1;
					end
				end
				ST_EMIT_A: begin
					if (slot_free) begin
						o_id_q    <= ra_id_q;
						o_oc_q    <= ra_oc_q;
						o_reg_q   <= ra_reg_q;
						o_last_q  <= ra_last_q;
						state_q   <= ra_last_q ? ST_IDLE : ST_EMIT_B;
					end
				end
				ST_EMIT_B: begin
					if (slot_free) begin
						o_id_q    <= rb_id_q;
						o_oc_q    <= OUTC_ASSIGNED;
						o_reg_q   <= rb_reg_q;
						o_last_q  <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/lsra_ram.sv
// ----------------------------------------------------------------------------
// lsra_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lsra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> verif/lsra_checker.sv
// ----------------------------------------------------------------------------
// lsra_checker
// Watches the request, result and configuration ports of the allocator,
// predicts every result in order and compares it field by field.
// ----------------------------------------------------------------------------
module lsra_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  lsra_pkg::mask_t       cfg_wr_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  lsra_pkg::req_t        req_type,
	input  logic [15:0]           interval_id,
	input  logic [15:0]           start_point,
	input  logic [15:0]           end_point,
	input  lsra_pkg::reg_t        fixed_register,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [15:0]           result_id,
	input  lsra_pkg::outc_t       outcome,
	input  lsra_pkg::reg_t        assigned_register,
	input  logic                  last,
	output int                    fail_count,
	output int                    pending
);
	import lsra_pkg::*;

	localparam int NREG = 16;
	localparam int NFIX = 16;

	typedef struct packed {
		logic [15:0] id;
		outc_t       oc;
		reg_t        rg;
		logic        lst;
	} alloc_result_t;

	alloc_result_t expected_results[$];

	mask_t       reg_enable;
	logic        act_live [NREG];
	logic [15:0] act_id   [NREG];
	logic [15:0] act_end  [NREG];
	int          fix_cnt;
	reg_t        fix_reg  [NFIX];
	logic [15:0] fix_lo   [NFIX];
	logic [15:0] fix_hi   [NFIX];
	logic [15:0] last_start;

	assign pending = expected_results.size();

	function automatic alloc_result_t mk(logic [15:0] id, outc_t oc, reg_t rg, logic lst);
		alloc_result_t r;
		r.id = id; r.oc = oc; r.rg = rg; r.lst = lst;
		return r;
	endfunction

	// append one predicted result to the tail of the queue
	task automatic queue_result(alloc_result_t r);
		expected_results = {expected_results, r};
	endtask

	function automatic bit pinned(int r, logic [15:0] s, logic [15:0] e);
		for (int i = 0; i < fix_cnt; i++)
			if (fix_reg[i] == reg_t'(r) && fix_hi[i] > s && fix_lo[i] < e)
				return 1;
		return 0;
	endfunction

	task automatic clear_tables();
		for (int r = 0; r < NREG; r++) act_live[r] = 0;
		fix_cnt = 0;
		last_start = '0;
	endtask

	// work out the results of one accepted request
	task automatic allocate(req_t rq, logic [15:0] id, logic [15:0] s, logic [15:0] e,
			reg_t fr);
		int best;
		if (rq == REQ_CLEAR) begin
			clear_tables();
			return;
		end
		if (rq == REQ_FIXED) begin
			if (fix_cnt >= NFIX || s >= e || fr == 0 || fr > NREG) begin
				queue_result(mk(id, OUTC_ERROR, '0, 1));
			end else begin
				fix_reg[fix_cnt] = fr;
				fix_lo[fix_cnt]  = s;
				fix_hi[fix_cnt]  = e;
				fix_cnt++;
				queue_result(mk(id, OUTC_ASSIGNED, fr, 1));
			end
			return;
		end
		if (rq != REQ_ALLOC || s < last_start || s >= e) begin
			queue_result(mk(id, OUTC_ERROR, '0, 1));
			return;
		end
		last_start = s;
		for (int r = 0; r < NREG; r++)
			if (act_live[r] && act_end[r] <= s) act_live[r] = 0;
		for (int r = 0; r < NREG; r++) begin
			if (reg_enable[r] && !act_live[r] && !pinned(r + 1, s, e)) begin
				act_live[r] = 1;
				act_id[r]   = id;
				act_end[r]  = e;
				queue_result(mk(id, OUTC_ASSIGNED, reg_t'(r + 1), 1));
				return;
			end
		end
		best = -1;
		for (int r = 0; r < NREG; r++)
			if (act_live[r] && (best < 0 || act_end[r] > act_end[best])) best = r;
		if (best >= 0 && act_end[best] > e) begin
			// furthest-ending interval gives up its register
			queue_result(mk(act_id[best], OUTC_SPILLED, '0, 0));
			act_id[best]  = id;
			act_end[best] = e;
			queue_result(mk(id, OUTC_ASSIGNED, reg_t'(best + 1), 1));
		end else begin
			queue_result(mk(id, OUTC_SPILLED, '0, 1));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		if (!arst_n) begin
			clear_tables();
			reg_enable = MASK_RESET;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (cfg_wr_en) reg_enable = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: id=%h outcome=%0d reg=%0d last=%b",
							result_id, outcome, assigned_register, last);
				end else begin
					want = expected_results.pop_front();
					if (want.id !== result_id || want.oc !== outcome ||
							want.rg !== assigned_register || want.lst !== last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp id=%h oc=%0d reg=%0d last=%b, got id=%h oc=%0d reg=%0d last=%b",
								want.id, want.oc, want.rg, want.lst,
								result_id, outcome, assigned_register, last);
					end
				end
			end
			if (in_valid && !in_stall)
				allocate(req_type, interval_id, start_point, end_point, fixed_register);
		end
	end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the allocator with batches of fixed and virtual intervals under
// changing register masks; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	import lsra_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_wr_en = 0;
	mask_t       cfg_wr_data = '0;
	logic        in_valid = 0;
	logic        in_stall;
	req_t        req_type = REQ_CLEAR;
	logic [15:0] interval_id = '0;
	logic [15:0] start_point = '0;
	logic [15:0] end_point = '0;
	reg_t        fixed_register = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [15:0] result_id;
	outc_t       outcome;
	reg_t        assigned_register;
	logic        last;
	int          fail_count;
	int          pending;
	bit          rx_busy_mode = 0;

	// an allocation sweeps both tables before it gives its result
	localparam int DRAIN_CYCLES = 40;
	localparam req_t REQ_BAD = 2'd3;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	linear_scan_register_allocator_core dut (
		.clk, .arst_n, .cfg_wr_en, .cfg_wr_data,
		.in_valid, .in_stall, .req_type, .interval_id, .start_point, .end_point,
		.fixed_register, .out_valid, .out_stall, .result_id, .outcome,
		.assigned_register, .last
	);

	lsra_checker chk (
		.clk, .arst_n, .cfg_wr_en, .cfg_wr_data,
		.in_valid, .in_stall, .req_type, .interval_id, .start_point, .end_point,
		.fixed_register, .out_valid, .out_stall, .result_id, .outcome,
		.assigned_register, .last, .fail_count, .pending
	);

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// result side: stalls switch between a busy mode and a free-running one
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0) rx_busy_mode <= !rx_busy_mode;
		out_stall <= rx_busy_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
	end

	// one transfer on the request channel, then an optional idle gap
	task automatic push_req(req_t rq, logic [15:0] id, logic [15:0] s, logic [15:0] e,
			reg_t fr);
		int g;
		in_valid <= 1;
		req_type <= rq;
		interval_id <= id;
		start_point <= s;
		end_point <= e;
		fixed_register <= fr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	// quiesce the block, then write the register mask
	task automatic set_mask(mask_t m);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// a clear gives no result, so let any trailing work finish
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 0;
	endtask

	// a clear, some fixed intervals, then virtual intervals in start order with some invalid requests mixed in
	task automatic run_batch(output int sent);
		int nfix, nvirt, pick;
		logic [15:0] cur, base;
		logic [16:0] e;
		sent = 0;
		push_req(REQ_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
			5'($urandom));
		base = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(65000, 65535))
			: 16'($urandom_range(0, 40000));
		nfix = ($urandom_range(0, 14) == 0) ? 18 : $urandom_range(0, 4);
		for (int i = 0; i < nfix; i++) begin
			cur = base + 16'($urandom_range(0, 60));
			e = 17'(cur) + 17'($urandom_range(1, 30));
			push_req(REQ_FIXED, 16'($urandom), cur, (e > 65535) ? 16'hFFFF : e[15:0],
				reg_t'($urandom_range(1, 16)));
			sent++;
		end
		cur = base;
		nvirt = $urandom_range(5, 30);
		for (int i = 0; i < nvirt; i++) begin
			cur = (cur > 65530) ? cur : cur + 16'($urandom_range(0, 4));
			e = 17'(cur) + 17'($urandom_range(1, 40));
			pick = $urandom_range(0, 99);
			if (pick < 88) begin
				push_req(REQ_ALLOC, 16'($urandom), cur,
					(e > 65535) ? 16'hFFFF : e[15:0], 5'($urandom));
			end else if (pick < 91) begin
				// random start, which may fall below the last accepted one
				push_req(REQ_ALLOC, 16'($urandom), 16'($urandom_range(0, 65535)),
					16'($urandom), 5'($urandom));
			end else if (pick < 94) begin
				// empty interval
				push_req(REQ_ALLOC, 16'($urandom), cur, cur - 16'($urandom_range(0, 3)),
					5'($urandom));
			end else if (pick < 97) begin
				push_req(REQ_BAD, 16'($urandom), 16'($urandom), 16'($urandom),
					5'($urandom));
			end else begin
				// fixed load with an out-of-range or random register
				push_req(REQ_FIXED, 16'($urandom), 16'($urandom), 16'($urandom),
					5'($urandom));
			end
			sent++;
		end
	endtask

	initial begin
		int total, n;
		mask_t m;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: each kind of request and each rejection but a full fixed table
		push_req(REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000, 5'd0);
		push_req(REQ_FIXED, 16'hFFFF, 16'd10, 16'd20, 5'd1);
		push_req(REQ_FIXED, 16'h0001, 16'd10, 16'd20, 5'd0);
		push_req(REQ_FIXED, 16'h0002, 16'd10, 16'd20, 5'd17);
		push_req(REQ_FIXED, 16'h0003, 16'd10, 16'd20, 5'd31);
		push_req(REQ_FIXED, 16'h0004, 16'd20, 16'd20, 5'd2);
		push_req(REQ_FIXED, 16'h0005, 16'd0, 16'hFFFF, 5'd16);
		push_req(REQ_BAD, 16'h0006, 16'd1, 16'd2, 5'd3);
		push_req(REQ_ALLOC, 16'h0007, 16'd5, 16'd15, 5'd0);
		push_req(REQ_ALLOC, 16'h0008, 16'd9, 16'd9, 5'd0);
		push_req(REQ_ALLOC, 16'h0009, 16'd4, 16'd30, 5'd0);
		push_req(REQ_ALLOC, 16'h8000, 16'd15, 16'hFFFF, 5'd0);
		push_req(REQ_ALLOC, 16'h000A, 16'hFFFE, 16'hFFFF, 5'd0);
		push_req(REQ_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31);

		// random phases, each under its own mask
		total = 0;
		for (int ph = 0; total < 1000; ph++) begin
			case (ph % 8)
				0: m = 16'h0001;
				1: m = 16'h0000;
				2: m = 16'hFFFF;
				3: m = 16'h8000;
				4: m = 16'h000F;
				default: m = mask_t'($urandom) & mask_t'($urandom);
			endcase
			set_mask(m);
			for (int b = 0; b < 3; b++) begin
				run_batch(n);
				total += n;
			end
		end
		set_mask(MASK_RESET);

		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/lsra_pkg.sv
hw/rtl/lsra_ram.sv
hw/rtl/linear_scan_register_allocator_core.sv
verif/lsra_checker.sv
verif/tb_top.sv
